// ----- rtl/pdtq_pkg.sv -----
`default_nettype none

package pdtq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH  = 16;
	localparam int PAYLOAD_BITS = 64;
	localparam int ADDR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

	// Field widths on the channels.
	localparam int TYPE_W     = 2;
	localparam int MSG_TYPE_W = 3;
	localparam int PAYLOAD_W  = 64;
	localparam int OCC_W      = 5;
	localparam int DROP_W     = 32;
	localparam int ENTRY_W    = TYPE_W + PAYLOAD_BITS;

	// Operation codes.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_POP     = 1'b1;

	// Message type codes.
	localparam logic [TYPE_W-1:0]     TYPE_START   = 2'd0;
	localparam logic [TYPE_W-1:0]     TYPE_UPDATE  = 2'd1;
	localparam logic [TYPE_W-1:0]     TYPE_END     = 2'd2;
	localparam logic [MSG_TYPE_W-1:0] MSG_TYPE_MAX = 3'd2;

	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic pop_read;
		logic pop_take;
		logic scan_start;
		logic scan;
		logic shift;
		logic append;
		logic finish;
	} pdtq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pop;
		logic type_ok;
		logic full;
		logic empty;
		logic scan_found;
		logic scan_none;
		logic shift_done;
		logic out_free;
	} pdtq_stat_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DISPATCH = 7'b0000010,
		ST_POP_WAIT = 7'b0000100,
		ST_SCAN     = 7'b0001000,
		ST_SHIFT    = 7'b0010000,
		ST_APPEND   = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} pdtq_state_t;

	// Folds a sum of two slot positions back into the ring.
	function automatic addr_t addr_add(input addr_t a, input addr_t b);
		logic [ADDR_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	function automatic addr_t addr_inc(input addr_t a);
		return addr_add(a, addr_t'(1));
	endfunction

	function automatic addr_t addr_dec(input addr_t a);
		return addr_add(a, addr_t'(QUEUE_DEPTH - 1));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pdtq_if.sv -----
`default_nettype none

// Message channel into the queue.
interface pdtq_msg_if import pdtq_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [MSG_TYPE_W-1:0] msg_type;
	logic [PAYLOAD_W-1:0]  msg_payload;

	modport source (output valid, output operation, output msg_type, output msg_payload,
		input ready);
	modport sink (input valid, input operation, input msg_type, input msg_payload,
		output ready);
endinterface

// Result channel out of the queue.
interface pdtq_res_if import pdtq_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic                 overflow_drop;
	logic                 out_valid;
	logic [TYPE_W-1:0]    out_type;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [OCC_W-1:0]     occupancy;
	logic [DROP_W-1:0]    drop_total;

	modport source (output valid, output accepted, output overflow_drop, output out_valid,
		output out_type, output out_payload, output occupancy, output drop_total,
		input ready);
	modport sink (input valid, input accepted, input overflow_drop, input out_valid,
		input out_type, input out_payload, input occupancy, input drop_total,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/pdtq_ctrl.sv -----
`default_nettype none

module pdtq_ctrl import pdtq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	output logic       msg_ready,
	input  pdtq_stat_t stat,
	output pdtq_cmd_t  cmd
);

	pdtq_state_t state_q;
	pdtq_state_t state_next;

	// Only a quiet controller takes a new message.
	assign msg_ready = (state_q == ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					cmd.load_item = 1'b1;
					state_next    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!stat.is_pop) begin
					if (!stat.type_ok) begin
						state_next = ST_FINISH;
					end else if (stat.full) begin
						cmd.scan_start = 1'b1;
						state_next     = ST_SCAN;
					end else begin
						state_next = ST_APPEND;
					end
				end else if (stat.empty) begin
					state_next = ST_FINISH;
				end else begin
					cmd.pop_read = 1'b1;
					state_next   = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				cmd.pop_take = 1'b1;
				state_next   = ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_found) begin
					state_next = ST_SHIFT;
				end else if (stat.scan_none) begin
					state_next = ST_APPEND;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_done) begin
					state_next = ST_APPEND;
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pdtq_datapath.sv -----
`default_nettype none

module pdtq_datapath import pdtq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdtq_cmd_t             cmd,
	output pdtq_stat_t            stat,
	input  logic                  operation,
	input  logic [MSG_TYPE_W-1:0] msg_type,
	input  logic [PAYLOAD_W-1:0]  msg_payload,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  accepted,
	output logic                  overflow_drop,
	output logic                  out_valid,
	output logic [TYPE_W-1:0]     out_type,
	output logic [PAYLOAD_W-1:0]  out_payload,
	output logic [OCC_W-1:0]      occupancy,
	output logic [DROP_W-1:0]     drop_total
);

	// Slot memory: type in the upper bits, payload below.
	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	// Item being worked on.
	logic                    item_op_q;
	logic [MSG_TYPE_W-1:0]   item_type_q;
	logic [PAYLOAD_BITS-1:0] item_payload_q;

	// Queue pointers and counters.
	addr_t             head_q;
	addr_t             tail_q;
	cnt_t              fill_q;
	logic [DROP_W-1:0] drop_q;

	// Scan and compaction walker.
	cnt_t  idx_q;
	logic  rd_pend_q;
	addr_t rd_idx_q;

	// Result flags collected while the item is handled.
	logic res_acc_q;
	logic res_drop_q;
	logic res_vld_q;

	// Output register.
	logic                 out_full_q;
	logic                 out_acc_q;
	logic                 out_drop_q;
	logic                 out_vld_q;
	logic [TYPE_W-1:0]    out_type_q;
	logic [PAYLOAD_W-1:0] out_payload_q;
	logic [OCC_W-1:0]     out_occ_q;
	logic [DROP_W-1:0]    out_total_q;

	logic [TYPE_W-1:0]       rd_type;
	logic [PAYLOAD_BITS-1:0] rd_payload;
	cnt_t                    idx_next;
	logic                    scan_found;
	logic                    scan_none;
	logic                    scan_issue;
	logic                    shift_more;
	logic                    shift_issue;
	logic                    shift_done;
	logic                    rd_en;
	addr_t                   rd_addr;
	logic                    wr_en;
	addr_t                   wr_addr;
	logic [ENTRY_W-1:0]      wr_data;
	logic                    out_free;

	assign rd_type    = rd_data_q[ENTRY_W-1 -: TYPE_W];
	assign rd_payload = rd_data_q[PAYLOAD_BITS-1:0];
	assign idx_next   = idx_q + cnt_t'(1);

	// Scan: the entry read last cycle is checked while the next one is fetched.
	assign scan_found = rd_pend_q && (rd_type == TYPE_UPDATE);
	assign scan_none  = rd_pend_q && !scan_found &&
		(CNT_W'(rd_idx_q) == (fill_q - cnt_t'(1)));
	assign scan_issue = cmd.scan && !scan_found && !scan_none && (idx_q < fill_q);

	// Compaction: fetch the entry behind the gap, write it one place forward.
	assign shift_more  = (idx_next < fill_q);
	assign shift_issue = cmd.shift && shift_more;
	assign shift_done  = !shift_more && !rd_pend_q;

	// Memory read port.
	always_comb begin
		rd_en   = cmd.pop_read || scan_issue || shift_issue;
		rd_addr = head_q;
		if (cmd.scan) begin
			rd_addr = addr_add(head_q, idx_q[ADDR_W-1:0]);
		end else if (cmd.shift) begin
			rd_addr = addr_add(head_q, idx_next[ADDR_W-1:0]);
		end
	end

	// Memory write port.
	always_comb begin
		wr_en   = cmd.append || (cmd.shift && rd_pend_q);
		wr_addr = addr_add(head_q, rd_idx_q);
		wr_data = rd_data_q;
		if (cmd.append) begin
			wr_addr = tail_q;
			wr_data = {item_type_q[TYPE_W-1:0], item_payload_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_op_q      <= operation;
			item_type_q    <= msg_type;
			item_payload_q <= msg_payload[PAYLOAD_BITS-1:0];
		end
	end

	// Pointers, counters and walker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			drop_q     <= '0;
			idx_q      <= '0;
			rd_pend_q  <= 1'b0;
			rd_idx_q   <= '0;
			res_acc_q  <= 1'b0;
			res_drop_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			rd_pend_q <= scan_issue || shift_issue;
			if (cmd.scan) begin
				rd_idx_q <= idx_q[ADDR_W-1:0];
			end else if (cmd.shift) begin
				rd_idx_q <= idx_q[ADDR_W-1:0];
			end

			if (cmd.load_item) begin
				res_acc_q  <= 1'b0;
				res_drop_q <= 1'b0;
				res_vld_q  <= 1'b0;
			end

			if (cmd.scan_start) begin
				idx_q      <= '0;
				res_drop_q <= 1'b1;
			end else if (cmd.scan) begin
				if (scan_found) begin
					idx_q <= CNT_W'(rd_idx_q);
				end else if (scan_issue) begin
					idx_q <= idx_next;
				end
			end else if (shift_issue) begin
				idx_q <= idx_next;
			end

			// No update queued: the head entry goes.
			if (cmd.scan && scan_none) begin
				head_q <= addr_inc(head_q);
				fill_q <= fill_q - cnt_t'(1);
			end

			// Gap closed: the tail moves back by one.
			if (cmd.shift && shift_done) begin
				tail_q <= addr_dec(tail_q);
				fill_q <= fill_q - cnt_t'(1);
			end

			if (cmd.pop_take) begin
				head_q    <= addr_inc(head_q);
				fill_q    <= fill_q - cnt_t'(1);
				res_vld_q <= 1'b1;
			end

			if (cmd.append) begin
				tail_q    <= addr_inc(tail_q);
				fill_q    <= fill_q + cnt_t'(1);
				res_acc_q <= 1'b1;
				if (res_drop_q && (drop_q != DROP_MAX)) begin
					drop_q <= drop_q + DROP_W'(1);
				end
			end
		end
	end

	// Output register; it frees up on the same edge as a result transfer.
	assign out_free = !out_full_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.finish) begin
			out_full_q <= 1'b1;
		end else if (res_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_acc_q     <= res_acc_q;
			out_drop_q    <= res_drop_q;
			out_vld_q     <= res_vld_q;
			out_type_q    <= res_vld_q ? rd_type : TYPE_START;
			out_payload_q <= res_vld_q ? PAYLOAD_W'(rd_payload) : '0;
			out_occ_q     <= OCC_W'(fill_q);
			out_total_q   <= drop_q;
		end
	end

	// Status to the controller.
	always_comb begin
		stat            = '0;
		stat.is_pop     = (item_op_q == OP_POP);
		stat.type_ok    = (item_type_q <= MSG_TYPE_MAX);
		stat.full       = (fill_q == CNT_W'(QUEUE_DEPTH));
		stat.empty      = (fill_q == '0);
		stat.scan_found = scan_found;
		stat.scan_none  = scan_none;
		stat.shift_done = shift_done;
		stat.out_free   = out_free;
	end

	assign res_valid     = out_full_q;
	assign accepted      = out_acc_q;
	assign overflow_drop = out_drop_q;
	assign out_valid     = out_vld_q;
	assign out_type      = out_type_q;
	assign out_payload   = out_payload_q;
	assign occupancy     = out_occ_q;
	assign drop_total    = out_total_q;

endmodule

`default_nettype wire

// ----- rtl/priority_drop_tx_queue_top.sv -----
// Bounded queue of typed messages (start, update, end) with an overflow policy: an enqueue
// into a full queue removes the oldest queued update and closes the gap, or removes the head
// entry when no update is queued, counts the drop in a saturating counter and then appends
// the new message. A pop returns the head entry or reports an empty queue. Every message
// transfer yields exactly one result transfer. A message is taken only while the controller
// is idle; a result may still wait in the output register at that time. A rejected type or
// a pop on an empty queue goes from dispatch straight to loading the result; any other pop
// reads the head entry first, and an enqueue into a queue with room appends first. An
// enqueue into a full queue walks the slot memory through its single read port, one slot
// per cycle to find the oldest update and one entry per cycle to close the gap. The
// controller is ready for the next message once the result is loaded; a result that waits
// for ready holds the controller until the output register frees up.
`default_nettype none

module priority_drop_tx_queue_top import pdtq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pdtq_msg_if.sink   msg,
	pdtq_res_if.source result
);

	pdtq_cmd_t  cmd;
	pdtq_stat_t stat;

	pdtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.msg_ready (msg.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pdtq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (msg.operation),
		.msg_type      (msg.msg_type),
		.msg_payload   (msg.msg_payload),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.accepted      (result.accepted),
		.overflow_drop (result.overflow_drop),
		.out_valid     (result.out_valid),
		.out_type      (result.out_type),
		.out_payload   (result.out_payload),
		.occupancy     (result.occupancy),
		.drop_total    (result.drop_total)
	);

endmodule

`default_nettype wire

// ----- rtl/pdtq_checker.sv -----
`default_nettype none

module pdtq_checker import pdtq_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 accepted,
	input logic                 overflow_drop,
	input logic                 out_valid,
	input logic [TYPE_W-1:0]    out_type,
	input logic [PAYLOAD_W-1:0] out_payload,
	input logic [OCC_W-1:0]     occupancy,
	input logic [DROP_W-1:0]    drop_total
);

	// The queue never reports more entries than it has slots.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(occupancy) <= QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	// A pop result carries no enqueue flags.
	a_pop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> !accepted && !overflow_drop)
		else $error("pop result with enqueue flags");

	// A drop happens only on an accepted enqueue that leaves the queue full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow_drop |->
			accepted && (drop_total != '0) && (int'(occupancy) == QUEUE_DEPTH))
		else $error("overflow drop without a full queue");

	// Without a popped entry the pop fields read as zero.
	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> (out_type == TYPE_START) && (out_payload == '0))
		else $error("pop fields set without a popped entry");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(occupancy) && $stable(drop_total))
		else $error("stalled result changed");

endmodule

bind priority_drop_tx_queue_top pdtq_checker u_pdtq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.accepted      (result.accepted),
	.overflow_drop (result.overflow_drop),
	.out_valid     (result.out_valid),
	.out_type      (result.out_type),
	.out_payload   (result.out_payload),
	.occupancy     (result.occupancy),
	.drop_total    (result.drop_total)
);

`default_nettype wire

// ----- dv/priority_drop_tx_queue_top_tb.sv -----
`timescale 1ns / 100ps

module priority_drop_tx_queue_top_tb;
	import pdtq_pkg::*;

	// Message type codes at the width of the message channel.
	localparam logic [MSG_TYPE_W-1:0] MT_START   = {1'b0, TYPE_START};
	localparam logic [MSG_TYPE_W-1:0] MT_UPDATE  = {1'b0, TYPE_UPDATE};
	localparam logic [MSG_TYPE_W-1:0] MT_END     = {1'b0, TYPE_END};
	localparam logic [MSG_TYPE_W-1:0] MT_BAD_LO  = MSG_TYPE_MAX + 3'd1;
	localparam logic [MSG_TYPE_W-1:0] MT_BAD_MID = 3'd5;
	localparam logic [MSG_TYPE_W-1:0] MT_BAD_HI  = '1;

	localparam logic [PAYLOAD_W-1:0] PL_ONES = '1;
	localparam logic [PAYLOAD_W-1:0] PL_ZERO = '0;

	localparam int RANDOM_ITEMS = 550;
	localparam int MODE_SPAN    = 50;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = QUEUE_DEPTH + 16;
	localparam int DIR_ROWS     = 25;

	typedef struct {
		logic                 accepted;
		logic                 overflow_drop;
		logic                 out_valid;
		logic [TYPE_W-1:0]    out_type;
		logic [PAYLOAD_W-1:0] out_payload;
		logic [OCC_W-1:0]     occupancy;
		logic [DROP_W-1:0]    drop_total;
	} queue_result_t;

	typedef struct {
		logic                  operation;
		logic [MSG_TYPE_W-1:0] msg_type;
		logic [PAYLOAD_W-1:0]  msg_payload;
		bit                    typed;
		queue_result_t         want;
	} dir_row_t;

	typedef enum {
		MODE_FILL,
		MODE_FILL_NO_UPDATE,
		MODE_DRAIN,
		MODE_MIXED
	} traffic_mode_t;

	// With a fresh queue every result field reads zero.
	localparam queue_result_t NO_RES = '{default: '0};

	logic clk;
	logic arst_n;

	pdtq_msg_if msg_ch();
	pdtq_res_if res_ch();

	priority_drop_tx_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.result (res_ch)
	);

	// Directed stimulus: reset corner cases, a full fill, rejects and every overflow flavor.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{OP_POP,     MT_START,   PL_ZERO,                1'b1, NO_RES},
		'{OP_ENQUEUE, MT_BAD_LO,  PL_ONES,                1'b1, NO_RES},
		'{OP_ENQUEUE, MT_BAD_HI,  PL_ZERO,                1'b1, NO_RES},
		'{OP_ENQUEUE, MT_START,   PL_ONES,                1'b0, NO_RES},
		'{OP_ENQUEUE, MT_UPDATE,  64'h0123_4567_89AB_CDEF, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_UPDATE,  64'hFEDC_BA98_7654_3210, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h5555_5555_5555_5555, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h0000_0000_0000_0001, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'h8000_0000_0000_0000, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h0F0F_0F0F_0F0F_0F0F, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'hF0F0_F0F0_F0F0_F0F0, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h3333_CCCC_3333_CCCC, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'hDEAD_BEEF_CAFE_F00D, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h0000_FFFF_0000_FFFF, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'hFFFF_0000_FFFF_0000, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h1248_1248_1248_1248, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'h7FFF_FFFF_FFFF_FFFE, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     PL_ZERO,                1'b0, NO_RES},
		'{OP_ENQUEUE, MT_BAD_MID, 64'h0BAD_0BAD_0BAD_0BAD, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h1111_2222_3333_4444, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_START,   64'h5555_6666_7777_8888, 1'b0, NO_RES},
		'{OP_ENQUEUE, MT_END,     64'h9999_AAAA_BBBB_CCCC, 1'b0, NO_RES},
		'{OP_POP,     MT_BAD_HI,  PL_ONES,                1'b0, NO_RES},
		'{OP_POP,     MT_START,   PL_ZERO,                1'b0, NO_RES}
	};

	// Mirror of the queue contents and counters.
	logic [TYPE_W-1:0]    mir_type    [QUEUE_DEPTH];
	logic [PAYLOAD_W-1:0] mir_payload [QUEUE_DEPTH];
	int                   mir_head;
	int                   mir_tail;
	int                   mir_fill;
	logic [DROP_W-1:0]    mir_drops;

	queue_result_t expected_results [$];

	bit no_idle   = 1'b0;
	int errors    = 0;
	int n_enq     = 0;
	int n_reject  = 0;
	int n_pop     = 0;
	int n_empty   = 0;
	int n_drop    = 0;
	int n_checked = 0;
	int max_occ   = 0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Random gap length: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// Advances the mirror by one message and returns the result it must produce.
	function automatic queue_result_t mirror_step(input logic op,
			input logic [MSG_TYPE_W-1:0] ty, input logic [PAYLOAD_W-1:0] pl);
		queue_result_t r;
		int hit;
		int i;
		int j;
		int dst;
		int src;
		r = NO_RES;
		if (op == OP_ENQUEUE) begin
			if (ty <= MSG_TYPE_MAX) begin
				if (mir_fill >= QUEUE_DEPTH) begin
					// Find the oldest queued update; without one, the head goes.
					hit = -1;
					for (i = 0; i < mir_fill && hit < 0; i++) begin
						if (mir_type[addr_t'((mir_head + i) % QUEUE_DEPTH)] == TYPE_UPDATE)
						begin
							hit = i;
						end
					end
					if (hit >= 0) begin
						for (j = hit; j + 1 < mir_fill; j++) begin
							dst = (mir_head + j) % QUEUE_DEPTH;
							src = (mir_head + j + 1) % QUEUE_DEPTH;
							mir_type[addr_t'(dst)]    = mir_type[addr_t'(src)];
							mir_payload[addr_t'(dst)] = mir_payload[addr_t'(src)];
						end
						mir_tail = (mir_tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					end else begin
						mir_head = (mir_head + 1) % QUEUE_DEPTH;
					end
					mir_fill--;
					if (mir_drops != DROP_MAX) begin
						mir_drops++;
					end
					r.overflow_drop = 1'b1;
				end
				mir_type[addr_t'(mir_tail)]    = ty[TYPE_W-1:0];
				mir_payload[addr_t'(mir_tail)] = pl & (PL_ONES >> (PAYLOAD_W - PAYLOAD_BITS));
				mir_tail = (mir_tail + 1) % QUEUE_DEPTH;
				mir_fill++;
				r.accepted = 1'b1;
			end
		end else if (mir_fill > 0) begin
			r.out_valid   = 1'b1;
			r.out_type    = mir_type[addr_t'(mir_head)];
			r.out_payload = mir_payload[addr_t'(mir_head)];
			mir_head = (mir_head + 1) % QUEUE_DEPTH;
			mir_fill--;
		end
		r.occupancy  = OCC_W'(mir_fill);
		r.drop_total = mir_drops;
		return r;
	endfunction

	// Drives one message, waits for its transfer and records what it must produce.
	task automatic send_msg(input logic op, input logic [MSG_TYPE_W-1:0] ty,
			input logic [PAYLOAD_W-1:0] pl, input bit typed, input queue_result_t want);
		int gap;
		queue_result_t pred;
		gap = no_idle ? 0 : idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_ch.valid       <= 1'b1;
		msg_ch.operation   <= op;
		msg_ch.msg_type    <= ty;
		msg_ch.msg_payload <= pl;
		do @(posedge clk); while (msg_ch.ready !== 1'b1);
		pred = mirror_step(op, ty, pl);
		expected_results.push_back(typed ? want : pred);
		if (op == OP_POP) begin
			n_pop++;
			if (!pred.out_valid) begin
				n_empty++;
			end
		end else if (pred.accepted) begin
			n_enq++;
		end else begin
			n_reject++;
		end
		if (pred.overflow_drop) begin
			n_drop++;
		end
		if (mir_fill > max_occ) begin
			max_occ = mir_fill;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Result side: ready stalls at random except in stretches with no idling.
	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (no_idle) begin
				res_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					stall = idle_gap();
				end
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no message outstanding");
				errors++;
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				check_field("accepted", 64'(want.accepted), 64'(res_ch.accepted));
				check_field("overflow_drop", 64'(want.overflow_drop),
					64'(res_ch.overflow_drop));
				check_field("out_valid", 64'(want.out_valid), 64'(res_ch.out_valid));
				check_field("out_type", 64'(want.out_type), 64'(res_ch.out_type));
				check_field("out_payload", 64'(want.out_payload), 64'(res_ch.out_payload));
				check_field("occupancy", 64'(want.occupancy), 64'(res_ch.occupancy));
				check_field("drop_total", 64'(want.drop_total), 64'(res_ch.drop_total));
			end
		end
	end

	// Watchdog: too long without any transfer ends the run.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1) ||
					(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				break;
			end
		end
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("priority_drop_tx_queue_top: mismatch");
		$finish;
	end

	// Main sequence: reset, directed table, then random traffic in phases.
	initial begin
		int i;
		int r;
		int enq_pct;
		traffic_mode_t mode;
		logic op;
		logic [MSG_TYPE_W-1:0] ty;
		logic [PAYLOAD_W-1:0] pl;

		msg_ch.valid       = 1'b0;
		msg_ch.operation   = OP_ENQUEUE;
		msg_ch.msg_type    = MT_START;
		msg_ch.msg_payload = PL_ZERO;
		mode = MODE_MIXED;
		for (i = 0; i < QUEUE_DEPTH; i++) begin
			mir_type[addr_t'(i)]    = TYPE_START;
			mir_payload[addr_t'(i)] = PL_ZERO;
		end
		mir_head  = 0;
		mir_tail  = 0;
		mir_fill  = 0;
		mir_drops = '0;

		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[n]) begin
			send_msg(dir_rows[n].operation, dir_rows[n].msg_type, dir_rows[n].msg_payload,
				dir_rows[n].typed, dir_rows[n].want);
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			// Each phase biases the mix so the queue both overflows and runs dry.
			if (i % MODE_SPAN == 0) begin
				mode = traffic_mode_t'($urandom_range(0, 3));
				no_idle = ($urandom_range(0, 3) == 0);
			end
			case (mode)
				MODE_FILL, MODE_FILL_NO_UPDATE: enq_pct = 85;
				MODE_DRAIN:                     enq_pct = 20;
				default:                        enq_pct = 50;
			endcase
			op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_POP;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				ty = MSG_TYPE_W'($urandom_range(MT_BAD_LO, MT_BAD_HI));
			end else if (mode == MODE_FILL_NO_UPDATE) begin
				ty = (r % 2 == 0) ? MT_START : MT_END;
			end else if (r < 45) begin
				ty = MT_UPDATE;
			end else if (r < 70) begin
				ty = MT_START;
			end else begin
				ty = MT_END;
			end
			case ($urandom_range(0, 9))
				0:       pl = PL_ZERO;
				1:       pl = PL_ONES;
				default: pl = {$urandom, $urandom};
			endcase
			send_msg(op, ty, pl, 1'b0, NO_RES);
		end

		@(negedge clk);
		msg_ch.valid <= 1'b0;
		no_idle = 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d enqueues with %0d overflow drops, %0d rejected types,",
			n_enq, n_drop, n_reject);
		$display("%0d pops (%0d on an empty queue), peak fill %0d of %0d, %0d results checked.",
			n_pop, n_empty, max_occ, QUEUE_DEPTH, n_checked);
		if (errors == 0) begin
			$display("priority_drop_tx_queue_top: match");
		end else begin
			$display("priority_drop_tx_queue_top: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/pdtq_pkg.sv
rtl/pdtq_if.sv
rtl/pdtq_ctrl.sv
rtl/pdtq_datapath.sv
rtl/priority_drop_tx_queue_top.sv
rtl/pdtq_checker.sv
dv/priority_drop_tx_queue_top_tb.sv
